### rtl/touch_detect_baseline_hysteresis_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the touch detector
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TOUCH_DETECT_BASELINE_HYSTERESIS_ASSERT_SVH
`define TOUCH_DETECT_BASELINE_HYSTERESIS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define TDB_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("touch detector check failed");
// Checked at every edge, reset included.
`define TDB_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("touch detector check failed");
`else
`define TDB_ASSERT(lbl, clk_s, rstn_s, prop)
`define TDB_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

### rtl/tdb_pkg.sv
// ----------------------------------------------------------------------------
// Touch detector package
// Shared widths, state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdb_pkg;

	localparam int SAMPLE_W         = 8;
	localparam int WINDOW_DEPTH_DEF = 8;

	typedef enum logic [1:0] {
		ST_NOT_INSTALLED = 2'd0,
		ST_DIED          = 2'd1,
		ST_TOUCHED       = 2'd2,
		ST_UNTOUCHED     = 2'd3
	} tdb_state_t;

	typedef enum logic [1:0] {
		REG_START_STATE = 2'd0,
		REG_ON_FACTOR   = 2'd1,
		REG_OFF_FACTOR  = 2'd2,
		REG_FAULT_CODE  = 2'd3
	} tdb_reg_t;

	localparam logic [4:0]          ON_FACTOR_RST  = 5'd10;
	localparam logic [4:0]          OFF_FACTOR_RST = 5'd5;
	localparam logic [SAMPLE_W-1:0] FAULT_CODE_RST = 8'd254;

endpackage

`default_nettype wire

### rtl/touch_detect_baseline_hysteresis.sv
// ----------------------------------------------------------------------------
// Touch detector with baseline and hysteresis
// One sensor channel: window of untouched samples, baseline, touch state.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser is the mode (0 process sample, 1 restart with
//   start_state), tdata is the 8-bit sample. Every transfer produces exactly
//   one result on m_axis: tdata[1:0] is the channel state, tdata[9:2] the
//   baseline that was in force before the sample was applied.
//   m_axis_tvalid is set in the cycle after the input transfer. One item is
//   taken every cycle while the receiver does not stall; the step needs no
//   divider because the window average is kept as a running quotient and
//   remainder, updated with two small division tables. The window itself
//   is a row of WINDOW_DEPTH cells that shift by one on every push.
//   When the receiver stalls, the result waits in the output register and
//   s_axis_tready drops until it is taken; it stays high while the result
//   is taken in the same cycle.
//   Reset clears the window, the baseline sum and the state (not installed)
//   and loads the register defaults. Registers sit on the APB port at
//   0x0 start_state, 0x4 on_factor, 0x8 off_factor, 0xC fault_code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "touch_detect_baseline_hysteresis_assert.svh"

module touch_detect_baseline_hysteresis
	import tdb_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] sample
	input  wire logic        s_axis_tuser,  // [0] mode
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // [1:0] channel_state, [9:2] baseline, [15:10] zero
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int RW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int TABN = 1 << SAMPLE_W;
	localparam logic signed [RW+1:0] DepthS = (RW+2)'(WINDOW_DEPTH);

	typedef logic [SAMPLE_W-1:0] qtab_t [TABN];
	typedef logic [RW-1:0]       rtab_t [TABN];

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int i = 0; i < TABN; i++) begin
			t[i] = SAMPLE_W'(i / WINDOW_DEPTH);
		end
		return t;
	endfunction

	function automatic rtab_t build_rtab();
		rtab_t t;
		for (int i = 0; i < TABN; i++) begin
			t[i] = RW'(i % WINDOW_DEPTH);
		end
		return t;
	endfunction

	localparam qtab_t QuotTab = build_qtab();
	localparam rtab_t RemTab  = build_rtab();

	// Configuration registers
	tdb_state_t          start_state_q;
	logic [4:0]          on_factor_q;
	logic [4:0]          off_factor_q;
	logic [SAMPLE_W-1:0] fault_code_q;

	tdb_reg_t reg_idx;
	logic     cfg_wr;

	assign reg_idx = tdb_reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= ST_UNTOUCHED;
			on_factor_q   <= ON_FACTOR_RST;
			off_factor_q  <= OFF_FACTOR_RST;
			fault_code_q  <= FAULT_CODE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_START_STATE: start_state_q <= tdb_state_t'(pwdata[1:0]);
				REG_ON_FACTOR:   on_factor_q   <= pwdata[4:0];
				REG_OFF_FACTOR:  off_factor_q  <= pwdata[4:0];
				REG_FAULT_CODE:  fault_code_q  <= pwdata[SAMPLE_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_STATE: prdata = {30'd0, start_state_q};
			REG_ON_FACTOR:   prdata = {27'd0, on_factor_q};
			REG_OFF_FACTOR:  prdata = {27'd0, off_factor_q};
			REG_FAULT_CODE:  prdata = {24'd0, fault_code_q};
			default:         prdata = '0;
		endcase
	end

	// Window: cell 0 holds the oldest sample, new samples enter at the top.
	logic [SAMPLE_W-1:0] cell_out [WINDOW_DEPTH];
	logic                push;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
			logic [SAMPLE_W-1:0] cell_in;
			if (gi == WINDOW_DEPTH - 1) begin : g_top
				assign cell_in = s_axis_tdata;
			end else begin : g_mid
				assign cell_in = cell_out[gi+1];
			end
			tdb_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (push),
				.din    (cell_in),
				.dout   (cell_out[gi])
			);
		end
	endgenerate

	// Window sum held as quotient and remainder by the window depth.
	logic [SAMPLE_W-1:0] quot_q;
	logic [RW-1:0]       rem_q;
	tdb_state_t          state_q;

	logic                in_xfer;
	logic [SAMPLE_W-1:0] base;
	logic [12:0]         thr_on;
	logic [12:0]         thr_off;
	tdb_state_t          state_nxt;
	tdb_state_t          mid_state;
	logic [SAMPLE_W-1:0] sample;

	logic signed [RW+1:0]       rem_sum;
	logic signed [SAMPLE_W+1:0] quot_sum;
	logic [RW-1:0]              rem_nxt;
	logic [SAMPLE_W-1:0]        quot_nxt;
	logic signed [SAMPLE_W+1:0] carry;

	logic                out_valid_q;
	tdb_state_t          res_state_q;
	logic [SAMPLE_W-1:0] res_base_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign sample        = s_axis_tdata;

	assign base    = (quot_q == '0) ? SAMPLE_W'(1) : quot_q;
	assign thr_on  = 13'(base) * 13'(on_factor_q);
	assign thr_off = 13'(base) * 13'(off_factor_q);

	always_comb begin
		state_nxt = state_q;
		mid_state = state_q;
		push      = 1'b0;
		if (s_axis_tuser) begin
			state_nxt = start_state_q;
		end else if (state_q != ST_NOT_INSTALLED) begin
			if (sample == fault_code_q) begin
				state_nxt = ST_DIED;
			end else begin
				// Both hysteresis tests run in turn, so one sample may set and
				// release the touch in the same step.
				if (state_q == ST_UNTOUCHED && 13'(sample) > thr_on) begin
					mid_state = ST_TOUCHED;
				end
				state_nxt = mid_state;
				if (mid_state == ST_TOUCHED && 13'(sample) < thr_off) begin
					state_nxt = ST_UNTOUCHED;
				end
				push = in_xfer && (state_nxt == ST_UNTOUCHED);
			end
		end
	end

	// Remainders from the tables land between minus and twice the depth, so
	// one correction step keeps the pair normalized.
	always_comb begin
		rem_sum = $signed({2'b00, rem_q}) + $signed({2'b00, RemTab[sample]})
			- $signed({2'b00, RemTab[cell_out[0]]});
		carry   = '0;
		rem_nxt = rem_sum[RW-1:0];
		if (rem_sum < 0) begin
			rem_nxt = RW'(rem_sum + DepthS);
			carry   = -(SAMPLE_W+2)'(1);
		end else if (rem_sum >= DepthS) begin
			rem_nxt = RW'(rem_sum - DepthS);
			carry   = (SAMPLE_W+2)'(1);
		end
		quot_sum = $signed({2'b00, quot_q}) + $signed({2'b00, QuotTab[sample]})
			- $signed({2'b00, QuotTab[cell_out[0]]}) + carry;
		quot_nxt = quot_sum[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q  <= '0;
			rem_q   <= '0;
			state_q <= ST_NOT_INSTALLED;
		end else if (in_xfer) begin
			state_q <= state_nxt;
			if (push) begin
				quot_q <= quot_nxt;
				rem_q  <= rem_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_state_q <= state_nxt;
			res_base_q  <= base;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_base_q, res_state_q};

	`TDB_ASSERT(a_died_sticky, clk, arst_n, (state_q == ST_DIED && !(in_xfer && s_axis_tuser)) |=> (state_q == ST_DIED))
	`TDB_ASSERT(a_base_nonzero, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata[9:2] != 8'd0))
	`TDB_ASSERT(a_sum_idle, clk, arst_n, !in_xfer |=> ($stable(quot_q) && $stable(rem_q)))
	`TDB_ASSERT_ALWAYS(a_rem_range, clk, (32'(rem_q) < WINDOW_DEPTH))

endmodule

`default_nettype wire

### rtl/tdb_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One untouched-window sample; on a push takes its neighbor's or the new one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdb_cell
	import tdb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic [SAMPLE_W-1:0] din,
	output logic      [SAMPLE_W-1:0] dout
);

	logic [SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the touch detector with baseline and hysteresis
// Sends sensor samples and restarts over the input stream and checks every
// result (channel state and baseline) against a cycle-free model of the
// channel, under several register settings and random idle and stall cycles.
// ----------------------------------------------------------------------------

module tb_top;
	import tdb_pkg::*;

	localparam int WIN_DEPTH = WINDOW_DEPTH_DEF;

	typedef struct packed {
		logic       mode;
		logic [7:0] sample;
		logic [2:0] gap;
	} scan_item_t;

	typedef struct packed {
		tdb_state_t state;
		logic [7:0] baseline;
	} touch_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] sample
	logic        s_axis_tuser = 1'b0;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // [1:0] channel_state, [9:2] baseline
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	touch_detect_baseline_hysteresis dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Channel model state and its copy of the registers.
	logic [7:0]  win [WIN_DEPTH] = '{default: 8'd0};
	int unsigned win_sum = 0;
	tdb_state_t  cur_state = ST_NOT_INSTALLED;
	tdb_state_t  cfg_start = ST_UNTOUCHED;
	logic [4:0]  cfg_on = ON_FACTOR_RST;
	logic [4:0]  cfg_off = OFF_FACTOR_RST;
	logic [7:0]  cfg_fault = FAULT_CODE_RST;

	scan_item_t    scan_q[$];
	touch_result_t touch_result_q[$];
	scan_item_t    on_bus;
	logic          tx_busy = 1'b0;
	int            gap_cnt = 0;
	int            rx_hold = 0;
	logic          no_gaps = 1'b0;
	int            err_cnt = 0;

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic touch_result_t touch_step(input logic mode, input logic [7:0] smp);
		touch_result_t r;
		int unsigned   b;
		b = win_sum / WIN_DEPTH;
		if (b == 0)
			b = 1;
		if (mode) begin
			cur_state = cfg_start;
		end else if (cur_state != ST_NOT_INSTALLED) begin
			if (smp == cfg_fault) begin
				cur_state = ST_DIED;
			end else begin
				// Both tests run in turn, so one sample can touch and release.
				if (cur_state == ST_UNTOUCHED && smp > b * cfg_on)
					cur_state = ST_TOUCHED;
				if (cur_state == ST_TOUCHED && smp < b * cfg_off)
					cur_state = ST_UNTOUCHED;
				if (cur_state == ST_UNTOUCHED) begin
					win_sum = win_sum - win[0] + smp;
					for (int i = 0; i < WIN_DEPTH - 1; i++)
						win[i] = win[i + 1];
					win[WIN_DEPTH - 1] = smp;
				end
			end
		end
		r.state = cur_state;
		r.baseline = b[7:0];
		return r;
	endfunction

	// Sender: the expected result is computed at the transfer of each item.
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			touch_result_q.push_back(touch_step(on_bus.mode, on_bus.sample));
			tx_busy = 1'b0;
		end
		if (!tx_busy && scan_q.size() > 0) begin
			if (gap_cnt < scan_q[0].gap) begin
				gap_cnt++;
			end else begin
				on_bus = scan_q.pop_front();
				gap_cnt = 0;
				tx_busy = 1'b1;
				s_axis_tdata <= on_bus.sample;
				s_axis_tuser <= on_bus.mode;
			end
		end
		s_axis_tvalid <= tx_busy;
	end

	// Receiver: checks each result transfer and then stalls for a drawn time.
	always @(posedge clk) begin
		touch_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (touch_result_q.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
			end else begin
				want = touch_result_q.pop_front();
				if (m_axis_tdata[1:0] !== want.state)
					report_mismatch($sformatf("state %0d, wanted %0d",
						m_axis_tdata[1:0], want.state));
				if (m_axis_tdata[9:2] !== want.baseline)
					report_mismatch($sformatf("baseline %0d, wanted %0d",
						m_axis_tdata[9:2], want.baseline));
			end
			rx_hold = no_gaps ? 0 : $urandom_range(0, 7);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		m_axis_tready <= (rx_hold == 0);
	end

	task automatic queue_scan(input logic mode, input logic [7:0] smp);
		scan_item_t it;
		it.mode = mode;
		it.sample = smp;
		it.gap = no_gaps ? 3'd0 : 3'($urandom_range(0, 7));
		scan_q.push_back(it);
	endtask

	task automatic wait_drained();
		while (scan_q.size() > 0 || tx_busy || touch_result_q.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write one register, mirror it in the model, then read it back.
	task automatic write_reg(input tdb_reg_t idx, input logic [7:0] val);
		logic [31:0] seen;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_START_STATE: cfg_start = tdb_state_t'(val[1:0]);
			REG_ON_FACTOR:   cfg_on = val[4:0];
			REG_OFF_FACTOR:  cfg_off = val[4:0];
			REG_FAULT_CODE:  cfg_fault = val;
			default: ;
		endcase
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		seen = prdata;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (seen !== {24'd0, val})
			report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, seen, val));
	endtask

	task automatic set_config(input tdb_state_t st, input logic [4:0] on_f,
			input logic [4:0] off_f, input logic [7:0] fault);
		write_reg(REG_START_STATE, {6'd0, st});
		write_reg(REG_ON_FACTOR, {3'd0, on_f});
		write_reg(REG_OFF_FACTOR, {3'd0, off_f});
		write_reg(REG_FAULT_CODE, fault);
	endtask

	function automatic logic [4:0] pick_factor();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 5'd0;
		if (r < 20)
			return 5'd31;
		if (r < 30)
			return 5'd1;
		return 5'($urandom_range(1, 31));
	endfunction

	function automatic logic [7:0] pick_fault();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		if (r < 30)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly samples near a drifting level, so the baseline can climb.
	function automatic logic [7:0] pick_sample(input int level);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			v = level + int'($urandom_range(0, 16)) - 8;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			return 8'(v);
		end
		if (r < 85)
			return 8'($urandom_range(0, 255));
		if (r < 93)
			return 8'($urandom_range(200, 255));
		return 8'($urandom_range(0, 3));
	endfunction

	initial begin
		tdb_state_t st;
		int         target;
		int         r;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'd0;
		pwdata <= 32'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: not installed, then restart and walk the states.
		queue_scan(1'b0, 8'hFF);
		queue_scan(1'b0, 8'd254);
		queue_scan(1'b1, 8'h00);
		queue_scan(1'b0, 8'd0);
		queue_scan(1'b0, 8'd11);
		queue_scan(1'b0, 8'd10);
		queue_scan(1'b0, 8'd4);
		queue_scan(1'b0, 8'd10);
		queue_scan(1'b0, 8'd200);
		queue_scan(1'b0, 8'd254);
		queue_scan(1'b0, 8'd3);
		queue_scan(1'b1, 8'h55);
		wait_drained();

		// Low on factor and high off factor: touch and release in one step.
		set_config(ST_TOUCHED, 5'd1, 5'd31, 8'd0);
		queue_scan(1'b1, 8'hAA);
		queue_scan(1'b0, 8'd100);
		queue_scan(1'b0, 8'd20);
		queue_scan(1'b0, 8'd2);
		queue_scan(1'b0, 8'd0);
		queue_scan(1'b1, 8'd0);
		wait_drained();

		// Both factors zero, top fault code, restart into each odd state.
		set_config(ST_NOT_INSTALLED, 5'd0, 5'd0, 8'd255);
		queue_scan(1'b0, 8'd0);
		queue_scan(1'b0, 8'd255);
		queue_scan(1'b1, 8'd7);
		queue_scan(1'b0, 8'd9);
		wait_drained();
		write_reg(REG_START_STATE, {6'd0, ST_DIED});
		queue_scan(1'b1, 8'd0);
		queue_scan(1'b0, 8'd1);
		queue_scan(1'b0, 8'd255);
		wait_drained();

		for (int p = 0; p < 13; p++) begin
			st = ($urandom_range(0, 9) < 7) ? ST_UNTOUCHED : tdb_state_t'($urandom_range(0, 3));
			set_config(st, pick_factor(), pick_factor(), pick_fault());
			no_gaps = (p % 4 == 2);
			target = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 255);
			queue_scan(1'b1, 8'($urandom_range(0, 255)));
			for (int i = 1; i < 150; i++) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					queue_scan(1'b1, 8'($urandom_range(0, 255)));
				else if (r < 6)
					queue_scan(1'b0, cfg_fault);
				else
					queue_scan(1'b0, pick_sample(target * i / 150));
			end
			wait_drained();
			no_gaps = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
